/* design/tournament_branch_predictor_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the tournament branch predictor unit.
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TOURNAMENT_BRANCH_PREDICTOR_UNIT_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tbp_pkg.sv */
// ---------------------------------------------------------------------------
// tbp_pkg
// Shared sizes, types and counter helpers of the tournament branch predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int HISTORY_BITS  = 16;
  localparam int COUNTER_BITS  = 2;
  localparam int ADDRESS_BITS  = 48;

  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int SIZE_BITS     = 4;
  localparam int PENALTY_BITS  = 8;

  localparam int IN_DATA_BITS   = ((ADDRESS_BITS + SIZE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = PENALTY_BITS + 4;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam int OUT_FIFO_DEPTH = 3;
  localparam int FIFO_PTR_BITS  = $clog2(OUT_FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = $clog2(OUT_FIFO_DEPTH + 1);

  typedef logic [COUNTER_BITS-1:0]  ctr_t;
  typedef logic [IDX_BITS-1:0]      idx_t;
  typedef logic [HISTORY_BITS-1:0]  hist_t;
  typedef logic [ADDRESS_BITS-1:0]  addr_t;
  typedef logic [SIZE_BITS-1:0]     size_t;
  typedef logic [PENALTY_BITS-1:0]  penalty_t;
  typedef logic [CFG_ADDR_BITS-3:0] reg_idx_t;

  localparam ctr_t     CTR_MAX       = {COUNTER_BITS{1'b1}};
  localparam ctr_t     CTR_WEAK      = ctr_t'(1) << (COUNTER_BITS - 1);
  localparam hist_t    HIST_RESET    = {HISTORY_BITS{1'b1}};
  localparam penalty_t PENALTY_RESET = penalty_t'(8);

  localparam reg_idx_t REG_MISPREDICT_PENALTY = reg_idx_t'(0);

  // Packed with the penalty in the lowest bits, as it goes out on tdata.
  typedef struct packed {
    logic     predict_taken;
    logic     predict_valid;
    logic     resolved_taken;
    logic     resolved_valid;
    penalty_t penalty;
  } result_t;

  typedef struct packed {
    logic [FIFO_CNT_BITS-1:0] count;
  } fifo_status_t;

  function automatic logic ctr_taken(input ctr_t c);
    return c[COUNTER_BITS-1];
  endfunction

  function automatic ctr_t ctr_inc(input ctr_t c);
    return (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + ctr_t'(1));
  endfunction

  function automatic ctr_t ctr_dec(input ctr_t c);
    return (c == ctr_t'(0)) ? ctr_t'(0) : ctr_t'(c - ctr_t'(1));
  endfunction

endpackage

`default_nettype wire

/* design/tbp_ram.sv */
// ---------------------------------------------------------------------------
// tbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/tbp_cfg.sv */
// ---------------------------------------------------------------------------
// tbp_cfg
// APB register file holding the mispredict penalty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbp_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tbp_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire logic [tbp_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic      [tbp_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                    pready,
  output tbp_pkg::penalty_t                       penalty
);

  tbp_pkg::penalty_t penalty_r;
  tbp_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[tbp_pkg::CFG_ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign penalty = penalty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      penalty_r <= tbp_pkg::PENALTY_RESET;
    end else if (wr_en && (reg_idx == tbp_pkg::REG_MISPREDICT_PENALTY)) begin
      penalty_r <= pwdata[tbp_pkg::PENALTY_BITS-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      tbp_pkg::REG_MISPREDICT_PENALTY: begin
        prdata = tbp_pkg::CFG_DATA_BITS'(penalty_r);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/tbp_out_fifo.sv */
// ---------------------------------------------------------------------------
// tbp_out_fifo
// Small result queue that decouples the predictor pipeline from the sink.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbp_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  tbp_pkg::result_t      push_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tbp_pkg::result_t      out_data,
  output tbp_pkg::fifo_status_t status
);

  tbp_pkg::result_t                   entry_r [tbp_pkg::OUT_FIFO_DEPTH];
  logic [tbp_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [tbp_pkg::FIFO_PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [tbp_pkg::FIFO_CNT_BITS-1:0]  count_r, count_nxt;
  logic                               pop;

  localparam logic [tbp_pkg::FIFO_PTR_BITS-1:0] PTR_LAST =
    tbp_pkg::FIFO_PTR_BITS'(tbp_pkg::OUT_FIFO_DEPTH - 1);

  assign out_valid    = (count_r != '0);
  assign out_data     = entry_r[rd_ptr_r];
  assign pop          = out_valid && out_ready;
  assign status.count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* design/tournament_branch_predictor_unit.sv */
// Each result word passes the registered counter-RAM read and the result queue to out_tdata.
// Throughput: one instruction word per cycle while in_tready is high, set by the single read
// port of each counter RAM. A resolved branch trains both RAMs in its accept cycle; the next
// read forwards that write. Reset is synchronous and active low; afterwards a clearing pass
// sets all TABLE_ENTRIES (1024) counters to weakly taken, and in_tready stays low meanwhile.
// ---------------------------------------------------------------------------
// tournament_branch_predictor_unit
// Gshare and bimodal predictors of two-bit counters with a global chooser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tournament_branch_predictor_unit_macros.svh"

module tournament_branch_predictor_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: instr_address, instr_size, zero padding (lowest bit first)
  input  wire logic [tbp_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // in_tuser: is_cond_branch
  input  wire logic [0:0]                         in_tuser,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // out_tdata: penalty, resolved_valid, resolved_taken, predict_valid,
  // predict_taken, zero padding (lowest bit first)
  output logic      [tbp_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [tbp_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  wire logic [tbp_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic      [tbp_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                                    cfg_pready
);

  localparam tbp_pkg::idx_t IDX_LAST = tbp_pkg::idx_t'(tbp_pkg::TABLE_ENTRIES - 1);
  localparam logic [tbp_pkg::FIFO_CNT_BITS-1:0] FIFO_FULL =
    tbp_pkg::FIFO_CNT_BITS'(tbp_pkg::OUT_FIFO_DEPTH);

  tbp_pkg::penalty_t     penalty_cfg;
  tbp_pkg::result_t      s1_result;
  tbp_pkg::result_t      fifo_data;
  tbp_pkg::fifo_status_t fifo_st;

  // Clearing pass
  logic          clearing_r, clearing_nxt;
  tbp_pkg::idx_t clr_idx_r, clr_idx_nxt;

  // Global state
  tbp_pkg::ctr_t  chooser_r, chooser_nxt;
  tbp_pkg::hist_t hist_r, hist_nxt;

  // Pending branch
  logic             pend_v_r;
  tbp_pkg::addr_t   pend_addr_r;
  tbp_pkg::size_t   pend_size_r;
  tbp_pkg::idx_t    pend_gidx_r, pend_bidx_r;
  logic             pend_chose_g_r;
  tbp_pkg::ctr_t    pend_gctr_r, pend_bctr_r;

  // Second stage
  logic              s1_v_r, s1_cond_r, s1_chose_g_r;
  logic              s1_rv_r, s1_rt_r;
  tbp_pkg::penalty_t s1_pen_r;

  // Last training write, kept for forwarding into the next read
  logic          wr_v_r;
  tbp_pkg::idx_t wr_gidx_r, wr_bidx_r;
  tbp_pkg::ctr_t wr_gdata_r, wr_bdata_r;

  // Input word
  logic           in_acc;
  tbp_pkg::addr_t in_addr;
  tbp_pkg::size_t in_size;
  logic           in_cond;

  // Resolution
  tbp_pkg::addr_t fall_addr;
  logic           taken, resolve, g_ok, b_ok, mispred;
  tbp_pkg::ctr_t  cur_gctr, cur_bctr, g_train, b_train;

  // RAM ports
  logic          ram_we;
  tbp_pkg::idx_t g_waddr, b_waddr, g_raddr, b_raddr;
  tbp_pkg::ctr_t g_wdata, b_wdata, g_rdata, b_rdata, g_fwd, b_fwd;

  logic [tbp_pkg::FIFO_CNT_BITS:0] fill;

  assign in_addr = in_tdata[tbp_pkg::ADDRESS_BITS-1:0];
  assign in_size = in_tdata[tbp_pkg::ADDRESS_BITS +: tbp_pkg::SIZE_BITS];
  assign in_cond = in_tuser[0];

  // Words in flight plus words queued must leave room for one more.
  assign fill      = (tbp_pkg::FIFO_CNT_BITS + 1)'(fifo_st.count) +
                     (tbp_pkg::FIFO_CNT_BITS + 1)'(s1_v_r);
  assign in_tready = !clearing_r &&
                     (fill < (tbp_pkg::FIFO_CNT_BITS + 1)'(tbp_pkg::OUT_FIFO_DEPTH));
  assign in_acc    = in_tvalid && in_tready;

  // A branch predicted last cycle has its counters on the RAM outputs;
  // otherwise they were captured into the pending registers.
  assign g_fwd    = (wr_v_r && (wr_gidx_r == pend_gidx_r)) ? wr_gdata_r : g_rdata;
  assign b_fwd    = (wr_v_r && (wr_bidx_r == pend_bidx_r)) ? wr_bdata_r : b_rdata;
  assign cur_gctr = s1_v_r ? g_fwd : pend_gctr_r;
  assign cur_bctr = s1_v_r ? b_fwd : pend_bctr_r;

  assign fall_addr = pend_addr_r + tbp_pkg::ADDRESS_BITS'(pend_size_r);
  assign taken     = (in_addr != fall_addr);
  assign resolve   = in_acc && pend_v_r;
  assign g_ok      = (tbp_pkg::ctr_taken(cur_gctr) == taken);
  assign b_ok      = (tbp_pkg::ctr_taken(cur_bctr) == taken);
  assign mispred   = pend_chose_g_r ? !g_ok : !b_ok;
  assign g_train   = taken ? tbp_pkg::ctr_inc(cur_gctr) : tbp_pkg::ctr_dec(cur_gctr);
  assign b_train   = taken ? tbp_pkg::ctr_inc(cur_bctr) : tbp_pkg::ctr_dec(cur_bctr);

  always_comb begin
    chooser_nxt = chooser_r;
    hist_nxt    = hist_r;
    if (resolve) begin
      if (pend_chose_g_r && !g_ok && b_ok) begin
        chooser_nxt = tbp_pkg::ctr_dec(chooser_r);
      end else if (!pend_chose_g_r && !b_ok && g_ok) begin
        chooser_nxt = tbp_pkg::ctr_inc(chooser_r);
      end
      hist_nxt = {hist_r[tbp_pkg::HISTORY_BITS-2:0], taken};
    end
  end

  always_comb begin
    clearing_nxt = clearing_r;
    clr_idx_nxt  = clr_idx_r;
    if (clearing_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_LAST) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  assign ram_we  = clearing_r || resolve;
  assign g_waddr = clearing_r ? clr_idx_r : pend_gidx_r;
  assign b_waddr = clearing_r ? clr_idx_r : pend_bidx_r;
  assign g_wdata = clearing_r ? tbp_pkg::CTR_WEAK : g_train;
  assign b_wdata = clearing_r ? tbp_pkg::CTR_WEAK : b_train;

  // The prediction indexes with the history that already holds the outcome this word resolves.
  assign b_raddr = in_addr[tbp_pkg::IDX_BITS-1:0];
  assign g_raddr = in_addr[tbp_pkg::IDX_BITS-1:0] ^ tbp_pkg::IDX_BITS'(hist_nxt);

  tbp_ram #(
    .WIDTH (tbp_pkg::COUNTER_BITS),
    .DEPTH (tbp_pkg::TABLE_ENTRIES)
  ) u_gshare_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  tbp_ram #(
    .WIDTH (tbp_pkg::COUNTER_BITS),
    .DEPTH (tbp_pkg::TABLE_ENTRIES)
  ) u_bimodal_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r     <= 1'b1;
      clr_idx_r      <= '0;
      chooser_r      <= tbp_pkg::CTR_WEAK;
      hist_r         <= tbp_pkg::HIST_RESET;
      pend_v_r       <= 1'b0;
      pend_addr_r    <= '0;
      pend_size_r    <= '0;
      pend_gidx_r    <= '0;
      pend_bidx_r    <= '0;
      pend_chose_g_r <= 1'b0;
      s1_v_r         <= 1'b0;
      wr_v_r         <= 1'b0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
      chooser_r  <= chooser_nxt;
      hist_r     <= hist_nxt;
      s1_v_r     <= in_acc;
      wr_v_r     <= resolve;
      if (in_acc) begin
        pend_v_r <= in_cond;
      end
      if (in_acc && in_cond) begin
        pend_addr_r    <= in_addr;
        pend_size_r    <= in_size;
        pend_gidx_r    <= g_raddr;
        pend_bidx_r    <= b_raddr;
        pend_chose_g_r <= tbp_pkg::ctr_taken(chooser_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cond_r    <= in_cond;
      s1_chose_g_r <= tbp_pkg::ctr_taken(chooser_nxt);
      s1_rv_r      <= resolve;
      s1_rt_r      <= resolve && taken;
      s1_pen_r     <= (resolve && mispred) ? penalty_cfg : '0;
    end
    if (resolve) begin
      wr_gidx_r  <= pend_gidx_r;
      wr_bidx_r  <= pend_bidx_r;
      wr_gdata_r <= g_train;
      wr_bdata_r <= b_train;
    end
    if (s1_v_r && s1_cond_r) begin
      pend_gctr_r <= g_fwd;
      pend_bctr_r <= b_fwd;
    end
  end

  always_comb begin
    s1_result.penalty        = s1_pen_r;
    s1_result.resolved_valid = s1_rv_r;
    s1_result.resolved_taken = s1_rt_r;
    s1_result.predict_valid  = s1_cond_r;
    s1_result.predict_taken  = s1_cond_r &&
      (s1_chose_g_r ? tbp_pkg::ctr_taken(g_fwd) : tbp_pkg::ctr_taken(b_fwd));
  end

  tbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_v_r),
    .push_data (s1_result),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (fifo_data),
    .status    (fifo_st)
  );

  assign out_tdata = tbp_pkg::OUT_DATA_BITS'(fifo_data);

  tbp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .penalty (penalty_cfg)
  );

  `TBP_ASSERT_IMP(a_fifo_room, s1_v_r, fifo_st.count < FIFO_FULL, "result queue overflow")
  `TBP_ASSERT_NXT(a_pend_set, in_acc && in_cond, pend_v_r, "conditional branch not left pending")
  `TBP_ASSERT_IMP(a_clear_quiet, clearing_r, !out_tvalid && !s1_v_r, "activity during clearing pass")
  `TBP_ASSERT_NXT(a_state_hold, !in_acc, $stable({chooser_r, hist_r}), "state moved without a word")

endmodule

`default_nettype wire
